// ===== rtl/sha256_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 hasher.
package sha256_pkg;

   localparam int ROUND_COUNT = 64;
   localparam int BLOCK_WORDS = 16;
   localparam int HASH_WORDS  = 8;

   localparam logic [7:0] PAD_MARK  = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;
   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'(ROUND_COUNT - 1);
   localparam logic [2:0] LAST_WORD  = 3'(HASH_WORDS - 1);

   localparam logic ACT_ABSORB = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   typedef logic [HASH_WORDS-1:0][31:0]  hash_words_type;
   typedef logic [BLOCK_WORDS-1:0][31:0] block_words_type;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_LOAD,
      CORE_ROUND,
      CORE_FOLD
   } core_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD80,
      ST_PADZ,
      ST_LEN,
      ST_HASH,
      ST_OUT
   } top_state_type;

   // Requests from the sequencer to the compression unit.
   typedef struct packed {
      logic       shift_en;
      logic [7:0] shift_byte;
      logic       start;
      logic       init;
   } core_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_stat_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      case (idx)
         3'd0: init_hash = 32'h6a09e667;
         3'd1: init_hash = 32'hbb67ae85;
         3'd2: init_hash = 32'h3c6ef372;
         3'd3: init_hash = 32'ha54ff53a;
         3'd4: init_hash = 32'h510e527f;
         3'd5: init_hash = 32'h9b05688c;
         3'd6: init_hash = 32'h1f83d9ab;
         3'd7: init_hash = 32'h5be0cd19;
         default: init_hash = 32'h6a09e667;
      endcase
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      case (idx)
         6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
         default: round_k = 32'h428a2f98;
      endcase
   endfunction

endpackage

// ===== rtl/sha256_core.sv =====
// SHA-256 compression unit: block window, message schedule and one round per cycle.
module sha256_core (
   input  logic                       clock,
   input  logic                       reset,
   input  sha256_pkg::core_cmd_type   cmd,
   output sha256_pkg::core_stat_type  stat,
   output sha256_pkg::hash_words_type hash_words
);
   import sha256_pkg::*;

   core_state_type  state_ff, state_in;
   logic [5:0]      rnd_ff, rnd_in;
   hash_words_type  h_ff, h_in;
   hash_words_type  v_ff, v_in;
   block_words_type win_ff, win_in;
   logic [31:0]     t1, t2, ch, maj, w_next;

   // The window doubles as the byte buffer and as the rolling message schedule.
   always_comb begin
      ch     = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      maj    = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1     = v_ff[7] + big_sigma1(v_ff[4]) + ch + round_k(rnd_ff) + win_ff[0];
      t2     = big_sigma0(v_ff[0]) + maj;
      w_next = win_ff[0] + small_sigma0(win_ff[1]) + win_ff[9] + small_sigma1(win_ff[14]);
   end

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      h_in     = h_ff;
      v_in     = v_ff;
      win_in   = win_ff;
      stat     = '{busy: (state_ff != CORE_IDLE), done: 1'b0};
      case (state_ff)
         CORE_IDLE: begin
            if (cmd.shift_en) begin
               for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                  win_in[i] = {win_ff[i][23:0], win_ff[i+1][31:24]};
               end
               win_in[BLOCK_WORDS-1] = {win_ff[BLOCK_WORDS-1][23:0], cmd.shift_byte};
            end
            if (cmd.start) begin
               state_in = CORE_LOAD;
            end
         end
         CORE_LOAD: begin
            v_in     = h_ff;
            rnd_in   = '0;
            state_in = CORE_ROUND;
         end
         CORE_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[BLOCK_WORDS-1] = w_next;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = CORE_FOLD;
            end
         end
         CORE_FOLD: begin
            for (int i = 0; i < HASH_WORDS; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
            end
            stat.done = 1'b1;
            state_in  = CORE_IDLE;
         end
         default: begin
            state_in = CORE_IDLE;
         end
      endcase
      if (cmd.init) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            h_in[i] = init_hash(3'(i));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
         for (int i = 0; i < HASH_WORDS; i++) begin
            h_ff[i] <= init_hash(3'(i));
         end
      end else begin
         state_ff <= state_in;
         h_ff     <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff <= rnd_in;
      v_ff   <= v_in;
      win_ff <= win_in;
   end

   assign hash_words = h_ff;

endmodule

// ===== rtl/sha256_hasher.sv =====
// Top level of the streaming SHA-256 hasher: byte intake, padding sequencer and digest output.
// An absorb beat shifts one byte into the core; the beat that completes a 64-byte block is
// followed by a compression (load, 64 rounds, fold) before the next beat. A finish beat pads
// one byte per cycle up to the block end, held while a block compresses, compresses one or
// two blocks, then presents eight digest beats. The single round datapath in sha256_core sets the rate.
// Reset is synchronous and active high; it restores the initial hash values and clears counts.
module sha256_hasher (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] action: 0 absorb, 1 finish
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);
   import sha256_pkg::*;

   top_state_type  state_ff, state_in;
   top_state_type  ret_ff, ret_in;
   logic [5:0]     fill_ff, fill_in;
   logic [63:0]    bitcnt_ff, bitcnt_in;
   logic [63:0]    len_ff, len_in;
   logic [2:0]     idx_ff, idx_in;
   core_cmd_type   core_cmd;
   core_stat_type  core_stat;
   hash_words_type hash_words;
   logic           req_take;
   logic           rsp_take;

   sha256_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cmd        (core_cmd),
      .stat       (core_stat),
      .hash_words (hash_words)
   );

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;

   // Sequencer. Every byte, message or padding, enters the core window one per cycle while no compression runs.
   // When the window fills, the core is started and the sequencer waits in ST_HASH,
   // resuming in the state held in ret_ff.
   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      fill_in    = fill_ff;
      bitcnt_in  = bitcnt_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      core_cmd   = '{shift_en: 1'b0, shift_byte: 8'd0, start: 1'b0, init: 1'b0};
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_take) begin
               if (req_tuser == ACT_ABSORB) begin
                  core_cmd.shift_en   = 1'b1;
                  core_cmd.shift_byte = req_tdata;
                  fill_in   = fill_ff + 6'd1;
                  bitcnt_in = bitcnt_ff + 64'd8;
                  if (fill_ff == FILL_LAST) begin
                     core_cmd.start = 1'b1;
                     ret_in   = ST_IDLE;
                     state_in = ST_HASH;
                  end
               end else begin
                  len_in   = bitcnt_ff;
                  state_in = ST_PAD80;
               end
            end
         end
         ST_PAD80: begin
            core_cmd.shift_en   = 1'b1;
            core_cmd.shift_byte = PAD_MARK;
            fill_in  = fill_ff + 6'd1;
            state_in = ST_PADZ;
            if (fill_ff == FILL_LAST) begin
               // The marker closed a block, so the length goes into an extra one.
               core_cmd.start = 1'b1;
               ret_in   = ST_PADZ;
               state_in = ST_HASH;
            end
         end
         ST_PADZ: begin
            if (fill_ff == LEN_START) begin
               state_in = ST_LEN;
            end else begin
               core_cmd.shift_en = 1'b1;
               fill_in = fill_ff + 6'd1;
               if (fill_ff == FILL_LAST) begin
                  core_cmd.start = 1'b1;
                  ret_in   = ST_PADZ;
                  state_in = ST_HASH;
               end
            end
         end
         ST_LEN: begin
            // Bit length goes in most significant byte first.
            core_cmd.shift_en   = 1'b1;
            core_cmd.shift_byte = len_ff[63:56];
            len_in  = {len_ff[55:0], 8'd0};
            fill_in = fill_ff + 6'd1;
            if (fill_ff == FILL_LAST) begin
               core_cmd.start = 1'b1;
               ret_in   = ST_OUT;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (core_stat.done) begin
               idx_in   = '0;
               state_in = ret_ff;
            end
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_take) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == LAST_WORD) begin
                  core_cmd.init = 1'b1;
                  fill_in   = '0;
                  bitcnt_in = '0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Digest words come straight from the chaining registers, which hold still until
   // the last beat is taken.
   assign rsp_tdata = hash_words[idx_ff];
   assign rsp_tuser = idx_ff;
   assign rsp_tlast = (idx_ff == LAST_WORD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ret_ff    <= ST_IDLE;
         fill_ff   <= '0;
         bitcnt_ff <= '0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         fill_ff   <= fill_in;
         bitcnt_ff <= bitcnt_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
   end

   // The block never takes a beat while a compression is running.
   assert property (@(posedge clock) disable iff (reset) req_tready |-> !core_stat.busy)
      else $error("input accepted while compression busy");

   // The compression unit only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset) core_stat.done |-> state_ff == ST_HASH)
      else $error("compression finished outside the wait state");

   // Taking the final digest beat restarts the message.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_tlast) |=> (fill_ff == 6'd0 && bitcnt_ff == 64'd0 && state_ff == ST_IDLE))
      else $error("message state not cleared after digest");

endmodule

// ===== dv/sha256_digest_board_pkg.sv =====
// Digest predictor and result scoreboard for the SHA-256 hasher testbench.
`timescale 1ns / 1ps

package sha256_digest_board_pkg;

   import sha256_pkg::*;

   typedef struct packed {
      logic [31:0] digest;
      logic [2:0]  position;
      logic        last_flag;
   } digest_beat_type;

   localparam logic [0:7][31:0] START_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [0:63][31:0] ROUND_CONST = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   class sha256_digest_board;

      logic [31:0]     chain [8];
      logic [7:0]      block_bytes [64];
      logic [5:0]      fill_level;
      logic [63:0]     bit_count;
      digest_beat_type expected_digests [$];
      int unsigned     error_count;

      function new();
         error_count = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) chain[i] = START_HASH[i];
         fill_level = '0;
         bit_count  = '0;
      endfunction

      static function logic [31:0] ror(input logic [31:0] x, input int n);
         logic [63:0] doubled;
         doubled = {x, x} >> n;
         return doubled[31:0];
      endfunction

      function void compress();
         logic [31:0] w [64];
         logic [31:0] v [8];
         logic [31:0] t1;
         logic [31:0] t2;
         for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
         for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
         for (int i = 0; i < 8; i++) v[i] = chain[i];
         for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
      endfunction

      // Called for every accepted input beat.
      function void note_input(input logic action, input logic [7:0] data);
         int              pos;
         logic [63:0]     length_bits;
         digest_beat_type beat;
         if (action == ACT_ABSORB) begin
            block_bytes[fill_level] = data;
            fill_level = fill_level + 6'd1;
            bit_count  = bit_count + 64'd8;
            if (fill_level == 6'd0) compress();
         end else begin
            length_bits = bit_count;
            pos = fill_level;
            block_bytes[pos] = PAD_MARK;
            pos++;
            // The length field no longer fits, so the padding spills into a second block.
            if (pos > 56) begin
               while (pos < 64) begin
                  block_bytes[pos] = 8'h00;
                  pos++;
               end
               compress();
               pos = 0;
            end
            while (pos < 56) begin
               block_bytes[pos] = 8'h00;
               pos++;
            end
            for (int i = 0; i < 8; i++) block_bytes[56+i] = length_bits[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
               beat = '{chain[i], 3'(i), (i == 7)};
               expected_digests = {expected_digests, beat};
            end
            restart();
         end
      endfunction

      // Called for every accepted result beat.
      function void check_result(input logic [31:0] digest, input logic [2:0] position,
                                 input logic last_flag);
         digest_beat_type got;
         digest_beat_type want;
         got = '{digest, position, last_flag};
         if (expected_digests.size() == 0) begin
            error_count++;
            $display("%0t: unexpected digest beat: expected none, actual word %h index %0d last %b",
                     $time, got.digest, got.position, got.last_flag);
         end else begin
            want = expected_digests.pop_front();
            if (got !== want) begin
               error_count++;
               $display("%0t: digest mismatch: expected word %h index %0d last %b, actual word %h index %0d last %b",
                        $time, want.digest, want.position, want.last_flag,
                        got.digest, got.position, got.last_flag);
            end
         end
      endfunction

      function int pending_count();
         return expected_digests.size();
      endfunction

   endclass

endpackage

// ===== dv/sha256_hasher_tb.sv =====
// Testbench top for the streaming SHA-256 hasher with directed and random messages.
`timescale 1ns / 1ps

module sha256_hasher_tb;

   import sha256_pkg::*;
   import sha256_digest_board_pkg::*;

   // Roughly how many input beats the run sends, directed messages included, before it stops.
   localparam int RANDOM_ITEMS = 380;
   // Cycles without any beat on either channel before the run is declared hung.
   // The worst honest wait is the one long receiver hold-off plus two compressions.
   localparam int STALL_LIMIT  = 5000;
   // Length of the deliberate receiver hold-off, and when it starts (in result beats seen).
   localparam int HOLD_OFF_CYCLES = 700;
   localparam int HOLD_OFF_AFTER  = 40;
   // Quiet time after the last digest beat, to catch any stray output.
   localparam int DRAIN_CYCLES = 200;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   sha256_digest_board board;

   int unsigned items_sent;
   int unsigned burst_left;
   int unsigned digest_beats_seen;

   sha256_hasher uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] data_byte
      .req_tuser  (req_tuser),    // [0] action
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [31:0] digest_word
      .rsp_tuser  (rsp_tuser),    // [2:0] word_index
      .rsp_tlast  (rsp_tlast)     // last_word
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Offers one beat and returns at the edge where it was taken. The sender works in bursts:
   // when a burst runs out, valid drops for a random gap before the next burst starts.
   // Inputs change only at rising edges, and valid gets at most one update per edge.
   task automatic send_beat(input logic action, input logic [7:0] data);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         // Every so often a long burst gives a stretch with no sender idling at all.
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      board.note_input(action, data);
      items_sent++;
      burst_left--;
   endtask

   // A message is a run of absorb beats with random bytes, closed by one finish beat.
   // The byte on the finish beat is random as well, since the block must ignore it.
   task automatic send_message(input int unsigned byte_count);
      for (int unsigned i = 0; i < byte_count; i++) send_beat(ACT_ABSORB, 8'($urandom));
      send_beat(ACT_FINISH, 8'($urandom));
   endtask

   // Message lengths lean toward the block and padding boundaries: 55 bytes still fit the
   // length field in one block, 56 and 63 force the extra padding block, 64 ends a block
   // exactly, and 119 and 120 repeat the fit and spill cases in a second block.
   // Short messages keep digests coming often.
   function automatic int unsigned pick_message_length();
      int unsigned len;
      case ($urandom_range(3))
         0, 1: begin
            case ($urandom_range(5))
               0: len = 55;
               1: len = 56;
               2: len = 63;
               3: len = 64;
               4: len = 119;
               default: len = 120;
            endcase
         end
         2: len = $urandom_range(0, 12);
         default: len = $urandom_range(0, 130);
      endcase
      return len;
   endfunction

   // Result checker: a beat counts when valid and ready were both high before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         digest_beats_seen++;
      end
   end

   // Receiver back-pressure. It switches between patterns of random length: always ready,
   // coin flip, mostly stalled and strict alternation. Once, mid-run, it holds ready low for
   // a long stretch while the sender keeps offering beats, so the block backs up to its input.
   initial begin : receiver
      int unsigned mode;
      int unsigned span_left;
      int unsigned hold_left;
      bit          held_off;
      rsp_tready = 1'b0;
      mode       = 0;
      span_left  = 0;
      hold_left  = 0;
      held_off   = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_off && digest_beats_seen >= HOLD_OFF_AFTER) begin
            held_off  = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            if (span_left == 0) begin
               mode      = $urandom_range(3);
               span_left = $urandom_range(10, 80);
            end
            span_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(1));
               2: rsp_tready <= ($urandom_range(3) == 0);
               default: rsp_tready <= span_left[0];
            endcase
         end
      end
   end

   // Watchdog: ends the run if neither channel moves a beat for too long.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: timeout, no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
   end

   // Main sequence: reset, directed messages, random messages, then drain.
   initial begin
      board             = new();
      items_sent        = 0;
      burst_left        = 0;
      digest_beats_seen = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = ACT_ABSORB;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The empty message, twice back to back with opposite bytes on the finish beat.
      send_beat(ACT_FINISH, 8'h00);
      send_beat(ACT_FINISH, 8'hff);
      // The classic three-byte message "abc".
      send_beat(ACT_ABSORB, 8'h61);
      send_beat(ACT_ABSORB, 8'h62);
      send_beat(ACT_ABSORB, 8'h63);
      send_beat(ACT_FINISH, 8'h5a);
      // Extreme byte values, a pattern that walks a one across the byte, and alternating bits.
      send_beat(ACT_ABSORB, 8'h00);
      send_beat(ACT_ABSORB, 8'hff);
      for (int i = 0; i < 8; i++) send_beat(ACT_ABSORB, 8'h01 << i);
      send_beat(ACT_ABSORB, 8'haa);
      send_beat(ACT_ABSORB, 8'h55);
      send_beat(ACT_FINISH, 8'ha5);
      // A single byte, to show the state was restored by the previous finish.
      send_beat(ACT_ABSORB, 8'h80);
      send_beat(ACT_FINISH, 8'h00);
      // The 64-bit bit counter cannot wrap within any run of practical length.

      while (items_sent < RANDOM_ITEMS) send_message(pick_message_length());

      req_tvalid <= 1'b0;
      while (board.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.error_count == 0 && board.pending_count() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
